// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file (vsf_checker.sv).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante, outside reset.
`define VSF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vsf assertion failed");

// Check cons in the cycle after ante, outside reset.
`define VSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vsf assertion failed");

`endif

// ===== src/vsf_pkg.sv =====
// ----------------------------------------------------------------------------
// vsf_pkg
// Shared types and constants of the variant support filter.
// ----------------------------------------------------------------------------
package vsf_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int DIST_BITS      = 8;
    localparam int CFG_ADDR_BITS  = 8;
    localparam int CFG_DATA_BITS  = 1;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_CHECK_PROPER_PAIRS        = 8'd0,
        CFG_SKIP_BEGIN_POSITION_CHECK = 8'd1,
        CFG_CHECK_READ_BIAS           = 8'd2,
        CFG_CHECK_STRAND_BIAS         = 8'd3
    } vsf_cfg_addr_t;

    // Mode bits handed to the decision logic
    typedef struct packed {
        logic check_proper_pairs;
        logic skip_begin_position_check;
        logic check_read_bias;
        logic check_strand_bias;
    } vsf_mode_t;

endpackage

// ===== src/vsf_in_if.sv =====
// ----------------------------------------------------------------------------
// vsf_in_if
// Variant record channel: valid/ready plus the read-support counters.
// ----------------------------------------------------------------------------
interface vsf_in_if #(
    parameter int COUNT_BITS = vsf_pkg::COUNT_BITS_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic [COUNT_BITS-1:0]          high_quality_count;
    logic [COUNT_BITS-1:0]          low_quality_count;
    logic [COUNT_BITS-1:0]          proper_pair_count;
    logic [COUNT_BITS-1:0]          first_in_pair_count;
    logic [COUNT_BITS-1:0]          reversed_count;
    logic [COUNT_BITS-1:0]          clipped_count;
    logic [vsf_pkg::DIST_BITS-1:0]  largest_distance;
    logic                           second_start_seen;
    logic                           third_start_seen;
    logic [COUNT_BITS-1:0]          coverage;

    modport source (
        output valid, high_quality_count, low_quality_count, proper_pair_count,
               first_in_pair_count, reversed_count, clipped_count, largest_distance,
               second_start_seen, third_start_seen, coverage,
        input  ready
    );
    modport sink (
        input  valid, high_quality_count, low_quality_count, proper_pair_count,
               first_in_pair_count, reversed_count, clipped_count, largest_distance,
               second_start_seen, third_start_seen, coverage,
        output ready
    );
endinterface

// ===== src/vsf_out_if.sv =====
// ----------------------------------------------------------------------------
// vsf_out_if
// Decision channel: valid/ready plus the pass flag.
// ----------------------------------------------------------------------------
interface vsf_out_if ();
    logic valid;
    logic ready;
    logic passes;

    modport source (output valid, passes, input ready);
    modport sink (input valid, passes, output ready);
endinterface

// ===== src/vsf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// vsf_cfg_if
// Configuration write channel: valid/ready, register index and write data.
// ----------------------------------------------------------------------------
interface vsf_cfg_if ();
    logic                                valid;
    logic                                ready;
    logic [vsf_pkg::CFG_ADDR_BITS-1:0]   addr;
    logic [vsf_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// ===== src/vsf_core.sv =====
// ----------------------------------------------------------------------------
// vsf_core
// Pass/fail decision for one registered variant record.
// ----------------------------------------------------------------------------
module vsf_core #(
    parameter int COUNT_BITS = vsf_pkg::COUNT_BITS_DEF
) (
    input  vsf_pkg::vsf_mode_t              mode,
    input  logic [COUNT_BITS-1:0]           high_quality_count,
    input  logic [COUNT_BITS-1:0]           low_quality_count,
    input  logic [COUNT_BITS-1:0]           proper_pair_count,
    input  logic [COUNT_BITS-1:0]           first_in_pair_count,
    input  logic [COUNT_BITS-1:0]           reversed_count,
    input  logic [COUNT_BITS-1:0]           clipped_count,
    input  logic [vsf_pkg::DIST_BITS-1:0]   largest_distance,
    input  logic                            second_start_seen,
    input  logic                            third_start_seen,
    input  logic [COUNT_BITS-1:0]           coverage,
    output logic                            passes
);
    localparam int RAW_W  = COUNT_BITS + 1;
    localparam int CORR_W = COUNT_BITS + 2;
    localparam int PROD_W = COUNT_BITS + 7;   // raw times 50 fits here

    logic [RAW_W-1:0]      raw;
    logic [COUNT_BITS-1:0] cov_eff;
    logic [PROD_W-1:0]     raw_p;
    logic [PROD_W-1:0]     cov_p;
    logic [CORR_W-1:0]     corr;
    logic ge35, ge40, ge20, ge30, gt26;
    logic very, prom;
    logic read_bias_ok, strand_ok, clip_ok, dist_ok, pp_ok, start_ok;

    always_comb
    begin
        raw     = RAW_W'(high_quality_count) + RAW_W'(low_quality_count);
        cov_eff = (coverage == '0) ? COUNT_BITS'(1) : coverage;
        raw_p   = PROD_W'(raw);
        cov_p   = PROD_W'(cov_eff);

        // ratio tests as cross-multiplications by small constants
        ge35 = (raw_p * PROD_W'(20)) >= (cov_p * PROD_W'(7));
        ge40 = (raw_p * PROD_W'(5))  >= (cov_p * PROD_W'(2));
        ge20 = (raw_p * PROD_W'(5))  >= cov_p;
        ge30 = (raw_p * PROD_W'(10)) >= (cov_p * PROD_W'(3));
        gt26 = (raw_p * PROD_W'(50)) >  (cov_p * PROD_W'(13));

        very = third_start_seen &&
               ((high_quality_count >= COUNT_BITS'(8) && ge35) ||
                (high_quality_count >= COUNT_BITS'(7) && ge40)) &&
               (!mode.check_proper_pairs || proper_pair_count >= COUNT_BITS'(6));

        prom = third_start_seen &&
               ((high_quality_count >= COUNT_BITS'(7) && ge20) ||
                (high_quality_count >= COUNT_BITS'(6) && ge30) ||
                (high_quality_count >= COUNT_BITS'(5) && ge40)) &&
               (!mode.check_proper_pairs || proper_pair_count >= COUNT_BITS'(4));

        start_ok = mode.skip_begin_position_check || second_start_seen;
        pp_ok    = !mode.check_proper_pairs || proper_pair_count >= COUNT_BITS'(2);

        read_bias_ok = !mode.check_read_bias || prom ||
                       (first_in_pair_count != '0 && RAW_W'(first_in_pair_count) < raw);

        // raw - 1 written as rev + 1 so raw of zero fails
        strand_ok = very || !mode.check_strand_bias ||
                    (prom && reversed_count != '0 && RAW_W'(reversed_count) < raw) ||
                    (reversed_count > COUNT_BITS'(1) &&
                     (RAW_W'(reversed_count) + RAW_W'(1)) < raw);

        clip_ok = (clipped_count <= COUNT_BITS'(1)) ||
                  ((RAW_W'(clipped_count) + RAW_W'(5)) <= raw);

        dist_ok = (largest_distance >= vsf_pkg::DIST_BITS'(10)) ||
                  (prom && high_quality_count >= COUNT_BITS'(10));

        // hq + lq/2 >= 3.9 exactly
        corr = (CORR_W'(high_quality_count) << 1) + CORR_W'(low_quality_count);

        passes = start_ok && pp_ok &&
                 (high_quality_count >= COUNT_BITS'(3)) &&
                 read_bias_ok && strand_ok && clip_ok && dist_ok &&
                 (corr >= CORR_W'(8)) &&
                 (gt26 || prom);
    end
endmodule

// ===== src/variant_support_filter.sv =====
// ----------------------------------------------------------------------------
// variant_support_filter
// Pass/fail filter on one variant's read support, one record per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   items     : sink of variant records (read-support counters and coverage).
//   decisions : source of one beat per record carrying the passes flag.
//   cfg       : register write channel, always ready; bit 0 of data sets the
//               addressed mode bit, unknown indexes are dropped. Write only
//               while no record is in flight.
// An accepted record passes through the record register and then the decision
// register before its decision beat. Throughput is one record per cycle while
// the receiver takes the beats; the decision logic between the two registers
// is a handful of constant multiplies and compares.
// Reset clears both valid flags and all mode bits (start check on, rest off).
// When the receiver stalls, the decision register holds its beat; the record
// register still takes one more record, then items.ready drops until the
// decision beat is taken. Ready is combinational from the receiver's ready.
// ----------------------------------------------------------------------------
module variant_support_filter #(
    parameter int COUNT_BITS = vsf_pkg::COUNT_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    vsf_in_if.sink       items,
    vsf_out_if.source    decisions,
    vsf_cfg_if.sink      cfg
);
    // mode bits
    vsf_pkg::vsf_mode_t mode_reg;

    // record stage
    logic                           rec_valid_reg;
    logic [COUNT_BITS-1:0]          hq_reg;
    logic [COUNT_BITS-1:0]          lq_reg;
    logic [COUNT_BITS-1:0]          pp_reg;
    logic [COUNT_BITS-1:0]          fip_reg;
    logic [COUNT_BITS-1:0]          rev_reg;
    logic [COUNT_BITS-1:0]          clip_reg;
    logic [vsf_pkg::DIST_BITS-1:0]  dist_reg;
    logic                           pos2_reg;
    logic                           pos3_reg;
    logic [COUNT_BITS-1:0]          cov_reg;

    // decision stage
    logic dec_valid_reg;
    logic passes_reg;
    logic passes_next;

    logic dec_ready;   // decision register free or emptied this cycle
    logic rec_ready;   // record register free or moving on this cycle
    logic rec_take;
    logic rec_move;

    assign dec_ready = !dec_valid_reg || decisions.ready;
    assign rec_ready = !rec_valid_reg || dec_ready;
    assign rec_take  = items.valid && rec_ready;
    assign rec_move  = rec_valid_reg && dec_ready;

    assign items.ready      = rec_ready;
    assign decisions.valid  = dec_valid_reg;
    assign decisions.passes = passes_reg;
    assign cfg.ready        = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (vsf_pkg::vsf_cfg_addr_t'(cfg.addr))
                vsf_pkg::CFG_CHECK_PROPER_PAIRS:
                    mode_reg.check_proper_pairs <= cfg.data[0];
                vsf_pkg::CFG_SKIP_BEGIN_POSITION_CHECK:
                    mode_reg.skip_begin_position_check <= cfg.data[0];
                vsf_pkg::CFG_CHECK_READ_BIAS:
                    mode_reg.check_read_bias <= cfg.data[0];
                vsf_pkg::CFG_CHECK_STRAND_BIAS:
                    mode_reg.check_strand_bias <= cfg.data[0];
                default:
                    ;   // drop writes to unknown indexes
            endcase
        end
    end

    // Valid flags of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
            dec_valid_reg <= 1'b0;
        end
        else
        begin
            if (rec_ready)
            begin
                rec_valid_reg <= items.valid;
            end
            if (dec_ready)
            begin
                dec_valid_reg <= rec_valid_reg;
            end
        end
    end

    // Record payload: capture on an accepted beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            hq_reg   <= items.high_quality_count;
            lq_reg   <= items.low_quality_count;
            pp_reg   <= items.proper_pair_count;
            fip_reg  <= items.first_in_pair_count;
            rev_reg  <= items.reversed_count;
            clip_reg <= items.clipped_count;
            dist_reg <= items.largest_distance;
            pos2_reg <= items.second_start_seen;
            pos3_reg <= items.third_start_seen;
            cov_reg  <= items.coverage;
        end
    end

    // Decision logic between the record and decision registers
    vsf_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .mode                (mode_reg),
        .high_quality_count  (hq_reg),
        .low_quality_count   (lq_reg),
        .proper_pair_count   (pp_reg),
        .first_in_pair_count (fip_reg),
        .reversed_count      (rev_reg),
        .clipped_count       (clip_reg),
        .largest_distance    (dist_reg),
        .second_start_seen   (pos2_reg),
        .third_start_seen    (pos3_reg),
        .coverage            (cov_reg),
        .passes              (passes_next)
    );

    // Decision payload: advance when the record moves on, hold while stalled
    always_ff @(posedge clk)
    begin
        if (rec_move)
        begin
            passes_reg <= passes_next;
        end
    end
endmodule

// ===== src/vsf_checker.sv =====
// ----------------------------------------------------------------------------
// vsf_checker
// Port-level checks of the variant support filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vsf_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_passes
);
    // records accepted but not yet delivered
    logic [1:0] occ_reg;
    logic [1:0] occ_next;

    always_comb
    begin
        occ_next = occ_reg;
        if (in_valid && in_ready && !(out_valid && out_ready))
        begin
            occ_next = occ_reg + 2'd1;
        end
        else if (!(in_valid && in_ready) && out_valid && out_ready)
        begin
            occ_next = occ_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 2'd0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // A stalled decision beat holds
    `VSF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(out_passes))
    // Receiver ready frees the pipe for a new record in the same cycle
    `VSF_ASSERT_SAME(a_no_bubble, clk, rst_n, out_ready, in_ready)
    // At most two records in flight
    `VSF_ASSERT_SAME(a_occ_max, clk, rst_n, 1'b1, occ_reg != 2'd3)
    // No decision beat without a record in flight
    `VSF_ASSERT_SAME(a_no_phantom, clk, rst_n, out_valid, occ_reg != 2'd0)
endmodule

bind variant_support_filter vsf_checker u_vsf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (items.valid),
    .in_ready   (items.ready),
    .out_valid  (decisions.valid),
    .out_ready  (decisions.ready),
    .out_passes (decisions.passes)
);
